FILE: src/irpc_pkg.sv
`default_nettype none

package irpc_pkg;

   localparam int REG_W     = 15;
   localparam int DATA_W    = 16;
   localparam int CMD_W     = 3;
   localparam int SRC_W     = 4;
   localparam int LEVEL_W   = 3;
   localparam int CNT_W     = 2;
   localparam int NUM_SLOTS = 9;
   localparam int NUM_CIA   = 2;
   localparam int BIT_IDX_W = 4;

   localparam logic [CNT_W-1:0] AUDIO_DELAY = 2'd1;
   localparam logic [CNT_W-1:0] PULSE_DELAY = 2'd2;

   localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WR_ENABLE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_WR_REQUEST = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PULSE      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CIA_LINE   = 3'd4;

   localparam logic [SRC_W-1:0] SRC_VBL     = 4'd0;
   localparam logic [SRC_W-1:0] SRC_DSKSYNC = 4'd1;
   localparam logic [SRC_W-1:0] SRC_EXTER   = 4'd2;
   localparam logic [SRC_W-1:0] SRC_DSKBLK  = 4'd3;
   localparam logic [SRC_W-1:0] SRC_TBE     = 4'd4;
   localparam logic [SRC_W-1:0] SRC_BLT     = 4'd5;
   localparam logic [SRC_W-1:0] SRC_AUD0    = 4'd6;
   localparam logic [SRC_W-1:0] SRC_AUD1    = 4'd7;
   localparam logic [SRC_W-1:0] SRC_AUD2    = 4'd8;
   localparam logic [SRC_W-1:0] SRC_AUD3    = 4'd9;
   localparam logic [SRC_W-1:0] SRC_RBF     = 4'd10;

   localparam logic [SRC_W-1:0] LINE_CIA1 = 4'd0;
   localparam logic [SRC_W-1:0] LINE_CIA2 = 4'd1;

   localparam int BIT_DSKBLK  = 1;
   localparam int BIT_CIA1    = 3;
   localparam int BIT_VBL     = 5;
   localparam int BIT_DSKSYNC = 12;
   localparam int BIT_EXTER   = 13;
   localparam int BIT_CIA2    = 13;
   localparam int BIT_MASTER  = 14;
   localparam int BIT_SET     = 15;

   localparam int SLOT_TBE  = 0;
   localparam int SLOT_CIA1 = 1;
   localparam int SLOT_BLT  = 2;
   localparam int SLOT_AUD0 = 3;
   localparam int SLOT_AUD1 = 4;
   localparam int SLOT_AUD2 = 5;
   localparam int SLOT_AUD3 = 6;
   localparam int SLOT_RBF  = 7;
   localparam int SLOT_CIA2 = 8;

   localparam logic [BIT_IDX_W-1:0] SLOT_BIT [NUM_SLOTS] = '{
      4'd0, 4'd3, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd13
   };

   localparam logic [REG_W-1:0] MASK_LEVEL6 = 15'h6000;
   localparam logic [REG_W-1:0] MASK_LEVEL5 = 15'h1800;
   localparam logic [REG_W-1:0] MASK_LEVEL4 = 15'h0780;
   localparam logic [REG_W-1:0] MASK_LEVEL3 = 15'h0070;
   localparam logic [REG_W-1:0] MASK_LEVEL2 = 15'h0008;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] write_data;
      logic [SRC_W-1:0]  source;
      logic              line_level;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } staged_item_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] ipl_level;
      logic               ipl_changed;
      logic [REG_W-1:0]   request_bits;
      logic [REG_W-1:0]   enable_bits;
   } result_type;

   function automatic logic [REG_W-1:0] apply_write(input logic [REG_W-1:0] value,
                                                    input logic [DATA_W-1:0] data);
      if (data[BIT_SET]) begin
         return value | data[REG_W-1:0];
      end
      return value & ~data[REG_W-1:0];
   endfunction

   function automatic logic [LEVEL_W-1:0] encode_level(input logic [REG_W-1:0] enable,
                                                       input logic [REG_W-1:0] request);
      logic [REG_W-1:0] masked;
      masked = enable & request;
      if (!enable[BIT_MASTER] || masked == '0) begin
         return 3'd0;
      end
      if ((masked & MASK_LEVEL6) != '0) return 3'd6;
      if ((masked & MASK_LEVEL5) != '0) return 3'd5;
      if ((masked & MASK_LEVEL4) != '0) return 3'd4;
      if ((masked & MASK_LEVEL3) != '0) return 3'd3;
      if ((masked & MASK_LEVEL2) != '0) return 3'd2;
      return 3'd1;
   endfunction

endpackage

`default_nettype wire

FILE: src/irpc_in_reg.sv
`default_nettype none

module irpc_in_reg
   import irpc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [DATA_W-1:0] req_write_data,
   input  wire logic [SRC_W-1:0]  req_source,
   input  wire logic              req_line_level,
   input  wire logic              advance,
   output staged_item_type        staged
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;
   logic     accept;

   assign req_ready = !valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in           = 1'b1;
         item_in.cmd        = req_cmd;
         item_in.write_data = req_write_data;
         item_in.source     = req_source;
         item_in.line_level = req_line_level;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign staged.valid = valid_ff;
   assign staged.item  = item_ff;

endmodule

`default_nettype wire

FILE: src/irpc_core.sv
`default_nettype none

module irpc_core
   import irpc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire staged_item_type staged,
   input  wire logic            advance,
   output result_type           result
);

   logic [REG_W-1:0]   enable_ff;
   logic [REG_W-1:0]   enable_in;
   logic [REG_W-1:0]   request_ff;
   logic [REG_W-1:0]   request_in;
   logic [NUM_CIA-1:0] cia_ff;
   logic [NUM_CIA-1:0] cia_in;
   logic [CNT_W-1:0]   cnt_ff [NUM_SLOTS];
   logic [CNT_W-1:0]   cnt_in [NUM_SLOTS];
   logic [LEVEL_W-1:0] level_ff;
   logic [LEVEL_W-1:0] level_in;
   logic               known_cmd;
   item_type           item;

   assign item = staged.item;

   always_comb begin
      enable_in  = enable_ff;
      request_in = request_ff;
      cia_in     = cia_ff;
      cnt_in     = cnt_ff;
      known_cmd  = 1'b1;
      case (item.cmd)
         CMD_TICK: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (cnt_ff[i] != '0) begin
                  cnt_in[i] = cnt_ff[i] - 2'd1;
                  if (cnt_ff[i] == 2'd1) begin
                     request_in[SLOT_BIT[i]] = 1'b1;
                  end
               end
            end
         end
         CMD_WR_ENABLE: begin
            enable_in = apply_write(enable_ff, item.write_data);
         end
         CMD_WR_REQUEST: begin
            request_in = apply_write(request_ff, item.write_data);
            if (cia_ff[0]) request_in[BIT_CIA1] = 1'b1;
            if (cia_ff[1]) request_in[BIT_CIA2] = 1'b1;
         end
         CMD_PULSE: begin
            case (item.source)
               SRC_VBL:     request_in[BIT_VBL]     = 1'b1;
               SRC_DSKSYNC: request_in[BIT_DSKSYNC] = 1'b1;
               SRC_EXTER:   request_in[BIT_EXTER]   = 1'b1;
               SRC_DSKBLK:  request_in[BIT_DSKBLK]  = 1'b1;
               SRC_TBE:     cnt_in[SLOT_TBE]        = PULSE_DELAY;
               SRC_BLT:     cnt_in[SLOT_BLT]        = PULSE_DELAY;
               SRC_AUD0:    cnt_in[SLOT_AUD0]       = AUDIO_DELAY;
               SRC_AUD1:    cnt_in[SLOT_AUD1]       = AUDIO_DELAY;
               SRC_AUD2:    cnt_in[SLOT_AUD2]       = AUDIO_DELAY;
               SRC_AUD3:    cnt_in[SLOT_AUD3]       = AUDIO_DELAY;
               SRC_RBF:     cnt_in[SLOT_RBF]        = PULSE_DELAY;
               default: ;
            endcase
         end
         CMD_CIA_LINE: begin
            case (item.source)
               LINE_CIA1: begin
                  if (item.line_level && !cia_ff[0]) cnt_in[SLOT_CIA1] = PULSE_DELAY;
                  cia_in[0] = item.line_level;
               end
               LINE_CIA2: begin
                  if (item.line_level && !cia_ff[1]) cnt_in[SLOT_CIA2] = PULSE_DELAY;
                  cia_in[1] = item.line_level;
               end
               default: ;
            endcase
         end
         default: begin
            known_cmd = 1'b0;
         end
      endcase
      level_in = known_cmd ? encode_level(enable_in, request_in) : level_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= '0;
         request_ff <= '0;
         cia_ff     <= '0;
         level_ff   <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (advance) begin
         enable_ff  <= enable_in;
         request_ff <= request_in;
         cia_ff     <= cia_in;
         level_ff   <= level_in;
         cnt_ff     <= cnt_in;
      end
   end

   assign result.ipl_level    = level_in;
   assign result.ipl_changed  = known_cmd && (level_in != level_ff);
   assign result.request_bits = request_in;
   assign result.enable_bits  = enable_in;

endmodule

`default_nettype wire

FILE: src/irpc_out_reg.sv
`default_nettype none

module irpc_out_reg
   import irpc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire result_type         result,
   output logic                    space,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [LEVEL_W-1:0]      rsp_ipl_level,
   output logic                    rsp_ipl_changed,
   output logic [REG_W-1:0]        rsp_request_bits,
   output logic [REG_W-1:0]        rsp_enable_bits
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;
   result_type result_in;

   assign space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (load) begin
         valid_in  = 1'b1;
         result_in = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_ipl_level    = result_ff.ipl_level;
   assign rsp_ipl_changed  = result_ff.ipl_changed;
   assign rsp_request_bits = result_ff.request_bits;
   assign rsp_enable_bits  = result_ff.enable_bits;

endmodule

`default_nettype wire

FILE: src/interrupt_request_priority_controller_top.sv
// Interrupt request and priority controller.
// The req channel carries one command item: a tick, an enable or request
// register write, a source pulse, or a new CIA line level. The rsp channel
// returns exactly one result item per command: the encoded priority level,
// a flag telling whether that command changed the level, and the request
// and enable registers as they stand after the command.
// An accepted item is held in an input register, processed by the state
// update logic and written into the result register once that register
// has space, and its result stays on rsp until it is taken. One item is
// accepted and one result delivered in every cycle while the receiver
// takes results; the throughput is set by the single state update
// stage.
// Reset clears the registers, CIA line levels, pending countdowns and the
// current level, and empties both the input and result registers.
// When the receiver stalls, the result register holds its item, the input
// register still takes one more item, and req_ready then drops until the
// result is taken.
`default_nettype none

module interrupt_request_priority_controller_top
   import irpc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [CMD_W-1:0]   req_cmd,
   input  wire logic [DATA_W-1:0]  req_write_data,
   input  wire logic [SRC_W-1:0]   req_source,
   input  wire logic               req_line_level,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [LEVEL_W-1:0]      rsp_ipl_level,
   output logic                    rsp_ipl_changed,
   output logic [REG_W-1:0]        rsp_request_bits,
   output logic [REG_W-1:0]        rsp_enable_bits
);

   staged_item_type staged;
   result_type      result;
   logic            space;
   logic            advance;

   assign advance = staged.valid && space;

   irpc_in_reg u_in_reg (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_write_data (req_write_data),
      .req_source     (req_source),
      .req_line_level (req_line_level),
      .advance        (advance),
      .staged         (staged)
   );

   irpc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .staged  (staged),
      .advance (advance),
      .result  (result)
   );

   irpc_out_reg u_out_reg (
      .clock            (clock),
      .reset            (reset),
      .load             (advance),
      .result           (result),
      .space            (space),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ipl_level    (rsp_ipl_level),
      .rsp_ipl_changed  (rsp_ipl_changed),
      .rsp_request_bits (rsp_request_bits),
      .rsp_enable_bits  (rsp_enable_bits)
   );

endmodule

`default_nettype wire

FILE: src/irpc_checker.sv
`default_nettype none

module irpc_checker
   import irpc_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [LEVEL_W-1:0] rsp_ipl_level,
   input wire logic [REG_W-1:0]   rsp_request_bits,
   input wire logic [REG_W-1:0]   rsp_enable_bits
);

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ipl_level)
         && $stable(rsp_request_bits) && $stable(rsp_enable_bits))
      else $error("stalled result changed");

   // Without the master enable no level is signaled.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_enable_bits[BIT_MASTER] |-> rsp_ipl_level == 3'd0)
      else $error("level with master enable clear");

   // A nonzero level needs an enabled pending request, and never exceeds six.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ipl_level != 3'd0 |->
         (rsp_request_bits & rsp_enable_bits) != '0 && rsp_ipl_level != 3'd7)
      else $error("level without enabled request");

   // No result is present right after reset is released.
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result present right after reset");

endmodule

bind interrupt_request_priority_controller_top irpc_checker u_irpc_checker (.*);

`default_nettype wire
